[rtl/ttb_pkg.sv]
`timescale 1ns / 1ps

package ttb_pkg;

    // Element coordinate widths; table extents are powers of two of these
    localparam int XW = 6;
    localparam int YW = 6;
    localparam int ZW = 2;
    localparam int MAX_X = 1 << XW;
    localparam int MAX_Y = 1 << YW;
    localparam int MAX_Z = 1 << ZW;

    // Element address is {z, y, x}
    localparam int AW = XW + YW + ZW;
    localparam int DEPTH = 1 << AW;

    localparam int SW = XW + 1;   // x/y size register width
    localparam int SZW = ZW + 1;  // z size register width
    localparam int VW = 16;

    localparam int QDEPTH = 2;
    localparam int QAW = $clog2(QDEPTH);

    // Command codes
    localparam logic [2:0] CMD_WR_SRC = 3'd0;
    localparam logic [2:0] CMD_WR_DST = 3'd1;
    localparam logic [2:0] CMD_RD_DST = 3'd2;
    localparam logic [2:0] CMD_FILL   = 3'd3;
    localparam logic [2:0] CMD_COPY   = 3'd4;
    localparam logic [2:0] CMD_TILE   = 3'd5;

    // Configuration register indexes
    localparam logic [2:0] CFG_DST_X = 3'd0;
    localparam logic [2:0] CFG_DST_Y = 3'd1;
    localparam logic [2:0] CFG_DST_Z = 3'd2;
    localparam logic [2:0] CFG_SRC_X = 3'd3;
    localparam logic [2:0] CFG_SRC_Y = 3'd4;
    localparam logic [2:0] CFG_SRC_Z = 3'd5;

    // Classified operation kinds
    localparam logic [2:0] OP_NOP    = 3'd0;
    localparam logic [2:0] OP_WR_SRC = 3'd1;
    localparam logic [2:0] OP_WR_DST = 3'd2;
    localparam logic [2:0] OP_RD_DST = 3'd3;
    localparam logic [2:0] OP_BLIT   = 3'd4;

    typedef struct packed {
        logic [2:0]          cmd;
        logic [XW-1:0]       x;
        logic [YW-1:0]       y;
        logic [ZW-1:0]       z;
        logic signed [VW-1:0] value;
        logic [XW-1:0]       origin_x;
        logic [YW-1:0]       origin_y;
        logic [SW-1:0]       width;
        logic [SW-1:0]       height;
    } in_item_t;

    typedef struct packed {
        logic                 status;
        logic signed [VW-1:0] read_value;
    } out_item_t;

    typedef struct packed {
        logic [SW-1:0]  dst_xsize;
        logic [SW-1:0]  dst_ysize;
        logic [SZW-1:0] dst_zsize;
        logic [SW-1:0]  src_xlen;
        logic [SW-1:0]  src_ylen;
        logic [SZW-1:0] src_zsize;
    } cfg_t;

    typedef struct packed {
        logic [2:0]           kind;
        logic                 status;
        logic                 fill;
        logic [XW-1:0]        x;
        logic [YW-1:0]        y;
        logic [ZW-1:0]        z;
        logic signed [VW-1:0] value;
        logic [XW-1:0]        ox;
        logic [YW-1:0]        oy;
        logic [XW-1:0]        last_x;
        logic [YW-1:0]        last_y;
        logic [ZW-1:0]        last_z;
    } op_t;

endpackage

[rtl/ttb_front.sv]
`timescale 1ns / 1ps

module ttb_front (
    input  ttb_pkg::cfg_t     cfg,
    input  logic              busy,
    input  logic              in_valid,
    output logic              in_stall,
    input  ttb_pkg::in_item_t in_data,
    input  logic              q_full,
    output logic              q_push,
    output ttb_pkg::op_t      q_din
);
    import ttb_pkg::*;

    logic [SW-1:0]  x_e;
    logic [SW-1:0]  y_e;
    logic [SZW-1:0] z_e;
    logic [SW-1:0]  ox_e;
    logic [SW-1:0]  oy_e;
    logic [SW-1:0]  room_x;
    logic [SW-1:0]  room_y;
    logic [SW-1:0]  nx_copy;
    logic [SW-1:0]  ny_copy;
    logic [SW-1:0]  nx_tile;
    logic [SW-1:0]  ny_tile;
    logic [SZW-1:0] nz;
    logic [SW-1:0]  lx_fill;
    logic [SW-1:0]  ly_fill;
    logic [SZW-1:0] lz_fill;
    logic [SW-1:0]  lx_copy;
    logic [SW-1:0]  ly_copy;
    logic [SW-1:0]  lx_tile;
    logic [SW-1:0]  ly_tile;
    logic [SZW-1:0] lz_copy;
    logic           src_oob;
    logic           dst_oob;
    logic           off_oob;
    logic           org_oob;

    assign in_stall = busy || q_full;
    assign q_push   = in_valid && !in_stall;

    always_comb
    begin
        x_e  = {1'b0, in_data.x};
        y_e  = {1'b0, in_data.y};
        z_e  = {1'b0, in_data.z};
        ox_e = {1'b0, in_data.origin_x};
        oy_e = {1'b0, in_data.origin_y};

        src_oob = (x_e >= cfg.src_xlen) || (y_e >= cfg.src_ylen) || (z_e >= cfg.src_zsize);
        dst_oob = (x_e >= cfg.dst_xsize) || (y_e >= cfg.dst_ysize) || (z_e >= cfg.dst_zsize);
        off_oob = (x_e >= cfg.dst_xsize) || (y_e >= cfg.dst_ysize);
        org_oob = (ox_e >= cfg.src_xlen) || (oy_e >= cfg.src_ylen);

        // room left in destination past the offset (meaningful only when in range)
        room_x  = cfg.dst_xsize - x_e;
        room_y  = cfg.dst_ysize - y_e;
        nx_copy = (cfg.src_xlen < room_x) ? cfg.src_xlen : room_x;
        ny_copy = (cfg.src_ylen < room_y) ? cfg.src_ylen : room_y;
        nx_tile = (in_data.width < room_x) ? in_data.width : room_x;
        ny_tile = (in_data.height < room_y) ? in_data.height : room_y;
        nz      = (cfg.src_zsize < cfg.dst_zsize) ? cfg.src_zsize : cfg.dst_zsize;

        lx_fill = cfg.dst_xsize - SW'(1);
        ly_fill = cfg.dst_ysize - SW'(1);
        lz_fill = cfg.dst_zsize - SZW'(1);
        lx_copy = nx_copy - SW'(1);
        ly_copy = ny_copy - SW'(1);
        lx_tile = nx_tile - SW'(1);
        ly_tile = ny_tile - SW'(1);
        lz_copy = nz - SZW'(1);

        q_din        = '0;
        q_din.kind   = OP_NOP;
        q_din.x      = in_data.x;
        q_din.y      = in_data.y;
        q_din.z      = in_data.z;
        q_din.value  = in_data.value;

        case (in_data.cmd)
            CMD_WR_SRC:
            begin
                q_din.status = src_oob;
                q_din.kind   = src_oob ? OP_NOP : OP_WR_SRC;
            end
            CMD_WR_DST:
            begin
                q_din.status = dst_oob;
                q_din.kind   = dst_oob ? OP_NOP : OP_WR_DST;
            end
            CMD_RD_DST:
            begin
                q_din.status = dst_oob;
                q_din.kind   = dst_oob ? OP_NOP : OP_RD_DST;
            end
            CMD_FILL:
            begin
                q_din.kind   = OP_BLIT;
                q_din.fill   = 1'b1;
                q_din.x      = '0;
                q_din.y      = '0;
                q_din.last_x = lx_fill[XW-1:0];
                q_din.last_y = ly_fill[YW-1:0];
                q_din.last_z = lz_fill[ZW-1:0];
            end
            CMD_COPY:
            begin
                if (off_oob)
                begin
                    q_din.status = 1'b1;
                end
                else
                begin
                    q_din.kind   = OP_BLIT;
                    q_din.last_x = lx_copy[XW-1:0];
                    q_din.last_y = ly_copy[YW-1:0];
                    q_din.last_z = lz_copy[ZW-1:0];
                end
            end
            CMD_TILE:
            begin
                if (off_oob || org_oob)
                begin
                    q_din.status = 1'b1;
                end
                else if (nx_tile != '0 && ny_tile != '0)
                begin
                    q_din.kind   = OP_BLIT;
                    q_din.ox     = in_data.origin_x;
                    q_din.oy     = in_data.origin_y;
                    q_din.last_x = lx_tile[XW-1:0];
                    q_din.last_y = ly_tile[YW-1:0];
                    q_din.last_z = lz_copy[ZW-1:0];
                end
            end
            default:
            begin
                q_din.kind = OP_NOP;
            end
        endcase
    end

endmodule

[rtl/ttb_queue.sv]
`timescale 1ns / 1ps

module ttb_queue (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  ttb_pkg::op_t din,
    input  logic         pop,
    output logic         full,
    output logic         valid,
    output ttb_pkg::op_t dout
);
    import ttb_pkg::*;

    op_t            slot_reg [QDEPTH];
    logic [QAW-1:0] wr_ptr_reg;
    logic [QAW-1:0] wr_ptr_next;
    logic [QAW-1:0] rd_ptr_reg;
    logic [QAW-1:0] rd_ptr_next;
    logic [QAW:0]   count_reg;
    logic [QAW:0]   count_next;

    assign full  = (count_reg == (QAW+1)'(QDEPTH));
    assign valid = (count_reg != '0);
    assign dout  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QAW'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + QAW'(1) : rd_ptr_reg;
        count_next  = count_reg + (QAW+1)'(push) - (QAW+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

[rtl/ttb_back.sv]
`timescale 1ns / 1ps

module ttb_back (
    input  logic               clk,
    input  logic               rst_n,
    input  ttb_pkg::cfg_t      cfg,
    output logic               busy,
    input  logic               q_valid,
    input  ttb_pkg::op_t       q_dout,
    output logic               q_pop,
    output logic               out_valid,
    input  logic               out_stall,
    output ttb_pkg::out_item_t out_data
);
    import ttb_pkg::*;

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_READ  = 3'd2;
    localparam logic [2:0] ST_BLIT  = 3'd3;
    localparam logic [2:0] ST_FIN   = 3'd4;

    logic [VW-1:0] dst_mem [DEPTH];
    logic [VW-1:0] src_mem [DEPTH];

    logic [2:0]    state_reg;
    logic [2:0]    state_next;
    logic [AW-1:0] clr_reg;
    logic [AW-1:0] clr_next;
    op_t           cur_reg;
    op_t           cur_next;
    logic [XW-1:0] i_reg;
    logic [XW-1:0] i_next;
    logic [YW-1:0] j_reg;
    logic [YW-1:0] j_next;
    logic [ZW-1:0] k_reg;
    logic [ZW-1:0] k_next;
    logic [XW-1:0] sxi_reg;
    logic [XW-1:0] sxi_next;
    logic [YW-1:0] syi_reg;
    logic [YW-1:0] syi_next;
    logic          pipe_valid_reg;
    logic          pipe_valid_next;
    logic [AW-1:0] pipe_addr_reg;
    logic [AW-1:0] pipe_addr_next;
    logic          out_valid_reg;
    logic          out_valid_next;
    out_item_t     out_data_reg;
    out_item_t     out_data_next;
    logic [VW-1:0] dst_rd_reg;
    logic [VW-1:0] src_rd_reg;

    logic          dst_we;
    logic [AW-1:0] dst_waddr;
    logic [VW-1:0] dst_wdata;
    logic          dst_re;
    logic [AW-1:0] dst_raddr;
    logic          src_we;
    logic [AW-1:0] src_waddr;
    logic [VW-1:0] src_wdata;
    logic          src_re;
    logic [AW-1:0] src_raddr;

    logic          out_free;
    logic          i_last;
    logic          j_last;
    logic          k_last;
    logic          sx_wrap;
    logic          sy_wrap;
    logic [XW-1:0] dx_pos;
    logic [YW-1:0] dy_pos;
    logic [AW-1:0] q_addr;

    assign busy      = (state_reg == ST_CLEAR);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_free  = !out_valid_reg || !out_stall;

    always_comb
    begin
        i_last  = (i_reg == cur_reg.last_x);
        j_last  = (j_reg == cur_reg.last_y);
        k_last  = (k_reg == cur_reg.last_z);
        sx_wrap = ({1'b0, sxi_reg} == cfg.src_xlen - SW'(1));
        sy_wrap = ({1'b0, syi_reg} == cfg.src_ylen - SW'(1));
        dx_pos  = cur_reg.x + i_reg;
        dy_pos  = cur_reg.y + j_reg;
        q_addr  = {q_dout.z, q_dout.y, q_dout.x};

        state_next      = state_reg;
        clr_next        = clr_reg;
        cur_next        = cur_reg;
        i_next          = i_reg;
        j_next          = j_reg;
        k_next          = k_reg;
        sxi_next        = sxi_reg;
        syi_next        = syi_reg;
        pipe_valid_next = 1'b0;
        pipe_addr_next  = pipe_addr_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_data_next   = out_data_reg;
        q_pop           = 1'b0;

        dst_we    = 1'b0;
        dst_waddr = q_addr;
        dst_wdata = q_dout.value;
        dst_re    = 1'b0;
        dst_raddr = q_addr;
        src_we    = 1'b0;
        src_waddr = q_addr;
        src_wdata = q_dout.value;
        src_re    = 1'b0;
        src_raddr = {k_reg, syi_reg, sxi_reg};

        // second stage of a blit: source word is back, write the destination
        if (pipe_valid_reg)
        begin
            dst_we    = 1'b1;
            dst_waddr = pipe_addr_reg;
            dst_wdata = cur_reg.fill ? cur_reg.value : src_rd_reg;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                dst_we    = 1'b1;
                dst_waddr = clr_reg;
                dst_wdata = '0;
                src_we    = 1'b1;
                src_waddr = clr_reg;
                src_wdata = '0;
                clr_next  = clr_reg + AW'(1);
                if (clr_reg == '1)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    case (q_dout.kind)
                        OP_RD_DST:
                        begin
                            q_pop      = 1'b1;
                            dst_re     = 1'b1;
                            state_next = ST_READ;
                        end
                        OP_BLIT:
                        begin
                            q_pop      = 1'b1;
                            cur_next   = q_dout;
                            i_next     = '0;
                            j_next     = '0;
                            k_next     = '0;
                            sxi_next   = q_dout.ox;
                            syi_next   = q_dout.oy;
                            state_next = ST_BLIT;
                        end
                        default:
                        begin
                            // single writes and rejected or empty commands finish here
                            if (out_free)
                            begin
                                q_pop                    = 1'b1;
                                dst_we                   = (q_dout.kind == OP_WR_DST);
                                src_we                   = (q_dout.kind == OP_WR_SRC);
                                out_valid_next           = 1'b1;
                                out_data_next.status     = q_dout.status;
                                out_data_next.read_value = '0;
                            end
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                if (out_free)
                begin
                    out_valid_next           = 1'b1;
                    out_data_next.status     = 1'b0;
                    out_data_next.read_value = dst_rd_reg;
                    state_next               = ST_IDLE;
                end
            end
            ST_BLIT:
            begin
                src_re          = !cur_reg.fill;
                pipe_valid_next = 1'b1;
                pipe_addr_next  = {k_reg, dy_pos, dx_pos};
                if (!i_last)
                begin
                    i_next   = i_reg + XW'(1);
                    sxi_next = sx_wrap ? '0 : sxi_reg + XW'(1);
                end
                else
                begin
                    i_next   = '0;
                    sxi_next = cur_reg.ox;
                    if (!j_last)
                    begin
                        j_next   = j_reg + YW'(1);
                        syi_next = sy_wrap ? '0 : syi_reg + YW'(1);
                    end
                    else
                    begin
                        j_next   = '0;
                        syi_next = cur_reg.oy;
                        k_next   = k_reg + ZW'(1);
                        if (k_last)
                        begin
                            state_next = ST_FIN;
                        end
                    end
                end
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    out_valid_next           = 1'b1;
                    out_data_next.status     = 1'b0;
                    out_data_next.read_value = '0;
                    state_next               = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_reg        <= '0;
            pipe_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_reg        <= clr_next;
            pipe_valid_reg <= pipe_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg       <= cur_next;
        i_reg         <= i_next;
        j_reg         <= j_next;
        k_reg         <= k_next;
        sxi_reg       <= sxi_next;
        syi_reg       <= syi_next;
        pipe_addr_reg <= pipe_addr_next;
        out_data_reg  <= out_data_next;
    end

    always_ff @(posedge clk)
    begin
        if (dst_we)
        begin
            dst_mem[dst_waddr] <= dst_wdata;
        end
        if (dst_re)
        begin
            dst_rd_reg <= dst_mem[dst_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (src_we)
        begin
            src_mem[src_waddr] <= src_wdata;
        end
        if (src_re)
        begin
            src_rd_reg <= src_mem[src_raddr];
        end
    end

endmodule

[rtl/tiled_table_blit_top.sv]
`timescale 1ns / 1ps

// Tiled table blit: destination and source tables of 64x64x4 signed 16-bit
// elements, one command word in, one status word out. After reset both tables
// are swept to zero, one element of each per cycle; in_stall stays high
// meanwhile while size registers can still be written. A front end range-checks
// and clips each command into a two-entry queue; the back end owns both tables
// (one write and one registered read port each) and runs the work. Source
// writes, destination writes and rejected commands finish in the idle state,
// a destination read goes via a read state, and fill, copy and tiled copy
// write each element through the single destination write port, then report.
// Write the size registers only while no command is in flight.
module tiled_table_blit_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  ttb_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output ttb_pkg::out_item_t out_data,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [6:0]         cfg_data
);
    import ttb_pkg::*;

    cfg_t cfg_reg;
    logic q_full;
    logic q_push;
    op_t  q_din;
    logic q_valid;
    op_t  q_dout;
    logic q_pop;
    logic busy;

    function automatic logic [SW-1:0] clamp_xy(input logic [SW-1:0] v, input logic [SW-1:0] max);
        logic [SW-1:0] r;
        r = v;
        if (v == '0)
        begin
            r = SW'(1);
        end
        else if (v > max)
        begin
            r = max;
        end
        return r;
    endfunction

    function automatic logic [SZW-1:0] clamp_z(input logic [SZW-1:0] v);
        logic [SZW-1:0] r;
        r = v;
        if (v == '0)
        begin
            r = SZW'(1);
        end
        else if (v > SZW'(MAX_Z))
        begin
            r = SZW'(MAX_Z);
        end
        return r;
    endfunction

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.dst_xsize <= SW'(1);
            cfg_reg.dst_ysize <= SW'(1);
            cfg_reg.dst_zsize <= SZW'(1);
            cfg_reg.src_xlen  <= SW'(1);
            cfg_reg.src_ylen  <= SW'(1);
            cfg_reg.src_zsize <= SZW'(1);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_DST_X: cfg_reg.dst_xsize <= clamp_xy(cfg_data, SW'(MAX_X));
                CFG_DST_Y: cfg_reg.dst_ysize <= clamp_xy(cfg_data, SW'(MAX_Y));
                CFG_DST_Z: cfg_reg.dst_zsize <= clamp_z(cfg_data[SZW-1:0]);
                CFG_SRC_X: cfg_reg.src_xlen  <= clamp_xy(cfg_data, SW'(MAX_X));
                CFG_SRC_Y: cfg_reg.src_ylen  <= clamp_xy(cfg_data, SW'(MAX_Y));
                CFG_SRC_Z: cfg_reg.src_zsize <= clamp_z(cfg_data[SZW-1:0]);
                default:
                begin
                    cfg_reg <= cfg_reg;
                end
            endcase
        end
    end

    ttb_front u_front (
        .cfg      (cfg_reg),
        .busy     (busy),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_din    (q_din)
    );

    ttb_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .din   (q_din),
        .pop   (q_pop),
        .full  (q_full),
        .valid (q_valid),
        .dout  (q_dout)
    );

    ttb_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .busy      (busy),
        .q_valid   (q_valid),
        .q_dout    (q_dout),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule
